### rtl/url_percent_decoder_top_macros.svh
// Assertion macros for the URL percent decoder checker.
// Used by upd_checker.sv; expects clk and rst_n in scope.
`ifndef URL_PERCENT_DECODER_TOP_MACROS_SVH
`define URL_PERCENT_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/upd_pkg.sv
// Shared types, character codes and helpers for the URL percent decoder.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none
package upd_pkg;

  localparam int BYTE_W    = 8;
  localparam int MAX_RES   = 3;
  localparam int CAND_N    = 5;
  localparam int CNT_W     = 2;

  localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [BYTE_W-1:0] PCT_CHAR   = 8'h25;
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] DIG0_CHAR  = 8'h30;
  localparam logic [BYTE_W-1:0] DIG9_CHAR  = 8'h39;
  localparam logic [BYTE_W-1:0] UPA_CHAR   = 8'h41;
  localparam logic [BYTE_W-1:0] UPF_CHAR   = 8'h46;
  localparam logic [BYTE_W-1:0] LOA_CHAR   = 8'h61;
  localparam logic [BYTE_W-1:0] LOF_CHAR   = 8'h66;
  localparam logic [BYTE_W-1:0] LETTER_OFS = 8'd10;

  localparam logic [1:0] STG_IDLE  = 2'd0;
  localparam logic [1:0] STG_PCT   = 2'd1;
  localparam logic [1:0] STG_DIGIT = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              is_last;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_t h;
    logic [BYTE_W-1:0] d;
    h = '0;
    d = '0;
    if (c >= DIG0_CHAR && c <= DIG9_CHAR) begin
      d = c - DIG0_CHAR;
      h.ok = 1'b1;
    end else if (c >= UPA_CHAR && c <= UPF_CHAR) begin
      d = c - UPA_CHAR + LETTER_OFS;
      h.ok = 1'b1;
    end else if (c >= LOA_CHAR && c <= LOF_CHAR) begin
      d = c - LOA_CHAR + LETTER_OFS;
      h.ok = 1'b1;
    end
    h.nib = d[3:0];
    return h;
  endfunction

endpackage
`default_nettype wire

### rtl/upd_ifs.sv
// Valid/ready channel interfaces for the URL percent decoder.
// Depends on upd_pkg for the byte width.
`default_nettype none
interface upd_in_if;
  import upd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
  modport mon    (input valid, ready, text_byte, end_of_text);
endinterface

interface upd_out_if;
  import upd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              has_byte;
  logic              is_last;

  modport source (output valid, out_byte, has_byte, is_last, input ready);
  modport sink   (input valid, out_byte, has_byte, is_last, output ready);
  modport mon    (input valid, ready, out_byte, has_byte, is_last);
endinterface
`default_nettype wire

### rtl/url_percent_decoder_top.sv
// URL percent decoder: one encoded byte per input beat, decoded bytes out.
// Depends on upd_pkg and the channel interfaces in upd_ifs.sv.
// The block takes one input beat per cycle and puts out its results one beat at
// a time; an input beat is taken only while the three-entry result buffer is empty
// or drains its last entry in the same cycle, so a beat that yields two or three
// results holds the input until all but its last result beat have drained. '+'
// gives a space, "%hh" gives the byte, a broken escape is passed through
// literally, zero bytes are dropped, and an end-of-text beat that yields nothing
// gives one empty beat with is_last set. The first result is registered and
// appears in the cycle after its input beat is taken.
`default_nettype none
module url_percent_decoder_top (
  input  wire       clk,
  input  wire       rst_n,
  upd_in_if.sink    in_bus,
  upd_out_if.source out_bus
);
  import upd_pkg::*;

  logic [1:0]        stage_r, stage_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  res_t              buf_r [MAX_RES];
  res_t              res_nxt [MAX_RES];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [BYTE_W-1:0] cand_byte [CAND_N];
  logic              cand_ok [CAND_N];
  logic [CNT_W-1:0]  n_new;
  logic              fresh;
  hex_t              hb, hh;
  logic [BYTE_W-1:0] b;
  logic              push, pop;

  assign b  = in_bus.text_byte;
  assign hb = hex_decode(b);
  assign hh = hex_decode(held_r);

  assign pop  = out_bus.valid && out_bus.ready;
  assign push = in_bus.valid && in_bus.ready;

  assign in_bus.ready     = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_bus.ready);
  assign out_bus.valid    = (cnt_r != '0);
  assign out_bus.out_byte = buf_r[0].out_byte;
  assign out_bus.has_byte = buf_r[0].has_byte;
  assign out_bus.is_last  = buf_r[0].is_last;

  // candidate slots: broken '%', broken held digit, fresh/decoded, flush '%', flush digit
  always_comb begin
    stage_nxt = STG_IDLE;
    fresh     = 1'b0;
    for (int i = 0; i < CAND_N; i++) begin
      cand_byte[i] = '0;
      cand_ok[i]   = 1'b0;
    end
    cand_byte[0] = PCT_CHAR;
    cand_byte[1] = held_r;
    cand_byte[3] = PCT_CHAR;

    unique case (stage_r)
      STG_PCT: begin
        if (hb.ok) begin
          stage_nxt = STG_DIGIT;
        end else begin
          cand_ok[0] = 1'b1;
          fresh      = 1'b1;
        end
      end
      STG_DIGIT: begin
        if (hb.ok && hh.ok) begin
          cand_byte[2] = {hh.nib, hb.nib};
          cand_ok[2]   = ({hh.nib, hb.nib} != '0);
        end else begin
          cand_ok[0] = 1'b1;
          cand_ok[1] = (held_r != '0);
          fresh      = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    if (fresh) begin
      if (b == PLUS_CHAR) begin
        cand_byte[2] = SPACE_CHAR;
        cand_ok[2]   = 1'b1;
      end else if (b == PCT_CHAR) begin
        stage_nxt = STG_PCT;
      end else begin
        cand_byte[2] = b;
        cand_ok[2]   = (b != '0);
      end
    end

    held_nxt = '0;
    if (stage_nxt == STG_DIGIT) begin
      held_nxt = b;
    end

    cand_byte[4] = held_nxt;
    if (in_bus.end_of_text) begin
      cand_ok[3] = (stage_nxt != STG_IDLE);
      cand_ok[4] = (stage_nxt == STG_DIGIT) && (held_nxt != '0);
      stage_nxt  = STG_IDLE;
      held_nxt   = '0;
    end
  end

  // compact the candidates into at most three result beats
  always_comb begin
    n_new = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      res_nxt[i] = '0;
    end
    for (int i = 0; i < CAND_N; i++) begin
      if (cand_ok[i] && n_new != CNT_W'(MAX_RES)) begin
        res_nxt[n_new].out_byte = cand_byte[i];
        res_nxt[n_new].has_byte = 1'b1;
        n_new = n_new + CNT_W'(1);
      end
    end
    if (in_bus.end_of_text) begin
      if (n_new == '0) begin
        res_nxt[0].is_last = 1'b1;
        n_new = CNT_W'(1);
      end else begin
        for (int i = 0; i < MAX_RES; i++) begin
          if (CNT_W'(i) == CNT_W'(n_new - CNT_W'(1))) begin
            res_nxt[i].is_last = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      cnt_nxt = n_new;
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= STG_IDLE;
      held_r  <= '0;
      cnt_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        stage_r <= stage_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  // load on accept, otherwise shift down on a drained beat
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_r[i] <= res_nxt[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/upd_checker.sv
// Port-level checks for url_percent_decoder_top, bound to every instance.
// Depends on upd_pkg and url_percent_decoder_top_macros.svh.
`default_nettype none
`include "url_percent_decoder_top_macros.svh"
module upd_checker (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_ready,
  input  wire                       out_valid,
  input  wire                       out_ready,
  input  wire [upd_pkg::BYTE_W-1:0] out_byte,
  input  wire                       out_has_byte,
  input  wire                       out_is_last
);
  import upd_pkg::*;

  `UPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_is_last), "result beat changed while stalled")
  `UPD_ASSERT_NOW(a_empty_is_last, out_valid && !out_has_byte, out_is_last && out_byte == '0, "empty beat without end mark")
  `UPD_ASSERT_NOW(a_no_zero_byte, out_valid && out_has_byte, out_byte != '0, "zero byte emitted")
  `UPD_ASSERT_NOW(a_stall_cause, !in_ready, out_valid, "input held with no pending result")

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_byte     (out_bus.out_byte),
  .out_has_byte (out_bus.has_byte),
  .out_is_last  (out_bus.is_last)
);
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for url_percent_decoder_top: directed and random text streams,
// decoded against an in-bench predictor under varying source idle and sink stall.
// Depends on upd_pkg, the channel interfaces in upd_ifs.sv and the decoder RTL.
module tb_top;
  import upd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } text_beat_t;

  logic clk;
  logic rst_n;

  upd_in_if  in_bus ();
  upd_out_if out_bus ();

  url_percent_decoder_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  text_beat_t text_queue[$];
  res_t       expected_beats[$];
  int         mismatch_count = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  logic       in_taken = 1'b0;

  logic [1:0]        dec_stage = STG_IDLE;
  logic [BYTE_W-1:0] dec_held = '0;
  res_t              step_res[MAX_RES];
  int                step_n;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic is_hex_char(input logic [BYTE_W-1:0] c);
    return (c >= DIG0_CHAR && c <= DIG9_CHAR) || (c >= UPA_CHAR && c <= UPF_CHAR) ||
           (c >= LOA_CHAR && c <= LOF_CHAR);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    if (c <= DIG9_CHAR) v = c - DIG0_CHAR;
    else if (c <= UPF_CHAR) v = c - UPA_CHAR + LETTER_OFS;
    else v = c - LOA_CHAR + LETTER_OFS;
    return v[3:0];
  endfunction

  // drop zero bytes and anything past the result limit
  function automatic void emit_char(input logic [BYTE_W-1:0] b);
    if (b != '0 && step_n < MAX_RES) begin
      step_res[step_n] = '{out_byte: b, has_byte: 1'b1, is_last: 1'b0};
      step_n++;
    end
  endfunction

  function automatic void take_fresh(input logic [BYTE_W-1:0] b);
    if (b == PLUS_CHAR) emit_char(SPACE_CHAR);
    else if (b == PCT_CHAR) dec_stage = STG_PCT;
    else emit_char(b);
  endfunction

  function automatic void decode_beat(input logic [BYTE_W-1:0] b, input logic eot);
    step_n = 0;
    case (dec_stage)
      STG_PCT: begin
        if (is_hex_char(b)) begin
          dec_held = b;
          dec_stage = STG_DIGIT;
        end else begin
          dec_stage = STG_IDLE;
          emit_char(PCT_CHAR);
          take_fresh(b);
        end
      end
      STG_DIGIT: begin
        dec_stage = STG_IDLE;
        if (is_hex_char(b)) begin
          emit_char({nibble_of(dec_held), nibble_of(b)});
        end else begin
          emit_char(PCT_CHAR);
          emit_char(dec_held);
          take_fresh(b);
        end
        dec_held = '0;
      end
      default: begin
        dec_stage = STG_IDLE;
        take_fresh(b);
      end
    endcase
    if (eot) begin
      if (dec_stage == STG_PCT) begin
        emit_char(PCT_CHAR);
      end else if (dec_stage == STG_DIGIT) begin
        emit_char(PCT_CHAR);
        emit_char(dec_held);
      end
      dec_stage = STG_IDLE;
      dec_held = '0;
      if (step_n == 0) begin
        step_res[0] = '{out_byte: '0, has_byte: 1'b0, is_last: 1'b1};
        step_n = 1;
      end else begin
        step_res[step_n-1].is_last = 1'b1;
      end
    end
    for (int i = 0; i < step_n; i++) expected_beats.push_back(step_res[i]);
  endfunction

  always @(negedge clk) begin : drive_blk
    text_beat_t nxt;
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (text_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = text_queue.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.text_byte   <= nxt.text_byte;
        in_bus.end_of_text <= nxt.end_of_text;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_blk
    res_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_beats.size() == 0) begin
          $error("out_byte: expected nothing, got %02h", out_bus.out_byte);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_bus.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_bus.out_byte);
            mismatch_count++;
          end
          if (out_bus.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, out_bus.has_byte);
            mismatch_count++;
          end
          if (out_bus.is_last !== want.is_last) begin
            $error("is_last: expected %0b, got %0b", want.is_last, out_bus.is_last);
            mismatch_count++;
          end
        end
      end
      in_taken = in_bus.valid && in_bus.ready;
      if (in_taken) decode_beat(in_bus.text_byte, in_bus.end_of_text);
    end
  end

  task automatic push_beat(input logic [BYTE_W-1:0] b, input logic eot);
    text_queue.push_back('{text_byte: b, end_of_text: eot});
  endtask

  function automatic logic [BYTE_W-1:0] rand_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return DIG0_CHAR + BYTE_W'(v);
    if ($urandom_range(1) == 0) return UPA_CHAR + BYTE_W'(v - 10);
    return LOA_CHAR + BYTE_W'(v - 10);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_plain_char();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(1, 255));
    while (is_hex_char(b));
    return b;
  endfunction

  // well-formed escapes with random content, random bytes, '+', some broken escapes
  task automatic push_random_text(input int n_items);
    logic [BYTE_W-1:0] tok[3];
    int tok_n;
    int kind;
    int sent;
    logic eot;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      tok_n = 1;
      if (kind < 35) begin
        tok[0] = BYTE_W'($urandom_range(1, 255));
      end else if (kind < 50) begin
        tok[0] = PLUS_CHAR;
      end else if (kind < 80) begin
        tok[0] = PCT_CHAR;
        if ($urandom_range(19) == 0) begin
          tok[1] = DIG0_CHAR;
          tok[2] = DIG0_CHAR;
        end else begin
          tok[1] = rand_hex_char();
          tok[2] = rand_hex_char();
        end
        tok_n = 3;
      end else if (kind < 88) begin
        tok[0] = PCT_CHAR;
        tok[1] = ($urandom_range(3) == 0) ? PCT_CHAR : rand_plain_char();
        tok_n = 2;
      end else if (kind < 96) begin
        tok[0] = PCT_CHAR;
        tok[1] = rand_hex_char();
        tok[2] = ($urandom_range(3) == 0) ? PLUS_CHAR : rand_plain_char();
        tok_n = 3;
      end else begin
        tok[0] = PCT_CHAR;
      end
      eot = ($urandom_range(9) == 0);
      for (int i = 0; i < tok_n; i++) push_beat(tok[i], eot && (i == tok_n - 1));
      sent += tok_n;
    end
  endtask

  task automatic drain();
    while (text_queue.size() != 0 || in_bus.valid || expected_beats.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.text_byte = '0;
    in_bus.end_of_text = 1'b0;
    out_bus.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_beat(8'h01, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(PLUS_CHAR, 1'b0);
    push_beat(PCT_CHAR, 1'b0);
    push_beat("4", 1'b0);
    push_beat("1", 1'b0);
    push_beat(PCT_CHAR, 1'b0);
    push_beat("f", 1'b0);
    push_beat("F", 1'b0);
    push_beat(PCT_CHAR, 1'b0);
    push_beat("0", 1'b0);
    push_beat("0", 1'b1);
    push_beat(PCT_CHAR, 1'b0);
    push_beat("G", 1'b0);
    push_beat(PCT_CHAR, 1'b0);
    push_beat("9", 1'b0);
    push_beat(PLUS_CHAR, 1'b0);
    push_beat(PCT_CHAR, 1'b0);
    push_beat("a", 1'b0);
    push_beat(PCT_CHAR, 1'b1);
    push_beat(PCT_CHAR, 1'b1);
    push_beat(PCT_CHAR, 1'b0);
    push_beat("B", 1'b1);
    push_beat("x", 1'b1);
    push_random_text(50);
    drain();

    idle_pct = 54;
    push_random_text(50);
    drain();

    // hold off until the decoder has drained completely
    idle_pct = 0;
    stall_pct = 54;
    repeat (20) @(posedge clk);
    push_random_text(50);
    drain();

    idle_pct = 7;
    stall_pct = 7;
    push_random_text(50);
    drain();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/upd_pkg.sv
rtl/upd_ifs.sv
rtl/url_percent_decoder_top.sv
rtl/upd_checker.sv
dv/tb_top.sv
